@@ design/gbte_pkg.sv @@
// Package for the gap buffer text store: sizes, operation codes, sequencer
// states and the structs of the text memory's write and read ports.
// No dependencies.
package gbte_pkg;

   // Store geometry
   localparam int CAPACITY  = 1024;
   localparam int CODE_BITS = 21;
   localparam int ADDR_W    = $clog2(CAPACITY);
   // Fixed field widths of positions, counts and the read index
   localparam int POS_W     = 11;
   localparam int IDX_W     = 10;

   // Request operation codes
   typedef enum logic [1:0] {
      OP_EDIT   = 2'd0,
      OP_INSERT = 2'd1,
      OP_READ   = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PLAN,
      ST_MOVE,
      ST_COMMIT,
      ST_RDWAIT,
      ST_RESP
   } state_type;

   // Text memory write port
   typedef struct packed {
      logic                 en;
      logic [ADDR_W-1:0]    addr;
      logic [CODE_BITS-1:0] data;
   } ram_wr_type;

   // Text memory read port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

endpackage

@@ design/gap_buffer_text_editor_store.sv @@
// Gap buffer text store: top level with the request sequencer, gap and
// cursor registers and the text memory. Depends on gbte_pkg and gbte_ram.
//
// A request beat is taken when start is high and busy is low; busy then
// stays high until the result has been shown. Each request gives exactly
// one result beat, rsp_valid high for a single cycle, which the receiver
// must take as it comes. An insert, an operation-three no-op and a read past
// the end of the text go from decode to the result; a read within the text
// waits for the read data first; a begin edit passes through plan, a slide
// of n entries and commit, where n is the number of entries that slide across
// the gap (|new gap start - old gap start|, up to 1024), with no slide when
// the gap already sits in place. The slide runs one entry per cycle through
// the text memory (one read port, one write port): each entry is read, and
// written to its new place the cycle after, while the next entry is read.
module gap_buffer_text_editor_store
   import gbte_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_operation,
   input  logic signed [POS_W-1:0] req_cursor_pos,
   input  logic                    req_has_mark,
   input  logic signed [POS_W-1:0] req_mark_pos,
   input  logic [CODE_BITS-1:0]    req_code_point,
   input  logic [IDX_W-1:0]        req_read_index,
   output logic                    rsp_valid,
   output logic [CODE_BITS-1:0]    rsp_read_code,
   output logic                    rsp_read_valid,
   output logic signed [POS_W-1:0] rsp_cursor_now,
   output logic [POS_W-1:0]        rsp_gap_position,
   output logic [POS_W-1:0]        rsp_gap_size,
   output logic                    rsp_full_drop
);

   // Control state
   state_type               state_ff, state_in;
   logic [POS_W-1:0]        gap_start_ff, gap_start_in;
   logic [POS_W-1:0]        gap_len_ff, gap_len_in;
   logic signed [POS_W-1:0] cursor_ff, cursor_in;

   // Captured request
   op_type                  op_ff, op_in;
   logic signed [POS_W-1:0] cpos_ff, cpos_in;
   logic                    has_mark_ff, has_mark_in;
   logic signed [POS_W-1:0] mark_ff, mark_in;
   logic [CODE_BITS-1:0]    code_ff, code_in;
   logic [IDX_W-1:0]        ridx_ff, ridx_in;

   // Edit plan and slide counters
   logic [POS_W-1:0]        tgt_ff, tgt_in;
   logic [POS_W-1:0]        grow_ff, grow_in;
   logic signed [POS_W-1:0] new_cur_ff, new_cur_in;
   logic                    dir_up_ff, dir_up_in;
   logic [POS_W-1:0]        left_ff, left_in;
   logic [POS_W-1:0]        rd_addr_ff, rd_addr_in;
   logic [POS_W-1:0]        wr_addr_ff, wr_addr_in;
   logic                    wr_pend_ff, wr_pend_in;

   // Result payload
   logic [CODE_BITS-1:0]    rcode_ff, rcode_in;
   logic                    rvalid_ff, rvalid_in;
   logic                    drop_ff, drop_in;

   // Memory ports
   ram_wr_type              wr;
   ram_rd_type              rd;
   logic [CODE_BITS-1:0]    rd_data;

   // Position arithmetic
   logic [POS_W-1:0]        len_w;
   logic signed [POS_W:0]   len_m1;
   logic signed [POS_W:0]   c_cl, m_cl, lo_w, hi_w;
   logic [POS_W:0]          tgt_x, grow_x;
   logic                    idx_hit;
   logic [POS_W-1:0]        phys_w;

   // Clamp a position to -1 .. top_v
   function automatic logic signed [POS_W:0] clamp_pos(
      input logic signed [POS_W:0] p,
      input logic signed [POS_W:0] top_v
   );
      logic signed [POS_W:0] r;
      r = p;
      if (r < -$signed((POS_W+1)'(1))) begin
         r = -$signed((POS_W+1)'(1));
      end
      if (r > top_v) begin
         r = top_v;
      end
      return r;
   endfunction

   gbte_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   // Text length and clamped edit positions
   always_comb begin
      len_w  = POS_W'(CAPACITY) - gap_len_ff;
      len_m1 = $signed({1'b0, len_w}) - $signed((POS_W+1)'(1));
      c_cl   = clamp_pos({cpos_ff[POS_W-1], cpos_ff}, len_m1);
      m_cl   = has_mark_ff ? clamp_pos({mark_ff[POS_W-1], mark_ff}, len_m1) : c_cl;
      lo_w   = (c_cl < m_cl) ? c_cl : m_cl;
      hi_w   = (c_cl < m_cl) ? m_cl : c_cl;
      tgt_x  = $unsigned(lo_w + $signed((POS_W+1)'(1)));
      grow_x = $unsigned(hi_w - lo_w);
      // Logical read index to physical slot
      idx_hit = {1'b0, ridx_ff} < len_w;
      phys_w  = ({1'b0, ridx_ff} < gap_start_ff) ? {1'b0, ridx_ff}
                                                  : {1'b0, ridx_ff} + gap_len_ff;
   end

   // Sequencer: next state, datapath updates and memory port drive
   always_comb begin
      state_in     = state_ff;
      gap_start_in = gap_start_ff;
      gap_len_in   = gap_len_ff;
      cursor_in    = cursor_ff;
      op_in        = op_ff;
      cpos_in      = cpos_ff;
      has_mark_in  = has_mark_ff;
      mark_in      = mark_ff;
      code_in      = code_ff;
      ridx_in      = ridx_ff;
      tgt_in       = tgt_ff;
      grow_in      = grow_ff;
      new_cur_in   = new_cur_ff;
      dir_up_in    = dir_up_ff;
      left_in      = left_ff;
      rd_addr_in   = rd_addr_ff;
      wr_addr_in   = wr_addr_ff;
      wr_pend_in   = wr_pend_ff;
      rcode_in     = rcode_ff;
      rvalid_in    = rvalid_ff;
      drop_in      = drop_ff;
      wr           = '0;
      rd           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in       = op_type'(req_operation);
               cpos_in     = req_cursor_pos;
               has_mark_in = req_has_mark;
               mark_in     = req_mark_pos;
               code_in     = req_code_point;
               ridx_in     = req_read_index;
               state_in    = ST_DECODE;
            end
         end

         ST_DECODE: begin
            rcode_in  = '0;
            rvalid_in = 1'b0;
            drop_in   = 1'b0;
            case (op_ff)
               OP_EDIT: begin
                  tgt_in     = tgt_x[POS_W-1:0];
                  grow_in    = grow_x[POS_W-1:0];
                  new_cur_in = lo_w[POS_W-1:0];
                  state_in   = ST_PLAN;
               end
               OP_INSERT: begin
                  if (gap_len_ff == '0) begin
                     drop_in = 1'b1;
                  end else begin
                     wr.en        = 1'b1;
                     wr.addr      = gap_start_ff[ADDR_W-1:0];
                     wr.data      = code_ff;
                     gap_start_in = gap_start_ff + POS_W'(1);
                     gap_len_in   = gap_len_ff - POS_W'(1);
                     cursor_in    = cursor_ff + POS_W'(1);
                  end
                  state_in = ST_RESP;
               end
               OP_READ: begin
                  if (idx_hit) begin
                     rd.en    = 1'b1;
                     rd.addr  = phys_w[ADDR_W-1:0];
                     state_in = ST_RDWAIT;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end

         // Direction and length of the slide
         ST_PLAN: begin
            wr_pend_in = 1'b0;
            if (tgt_ff < gap_start_ff) begin
               dir_up_in  = 1'b0;
               left_in    = gap_start_ff - tgt_ff;
               rd_addr_in = gap_start_ff - POS_W'(1);
               wr_addr_in = gap_start_ff + gap_len_ff - POS_W'(1);
               state_in   = ST_MOVE;
            end else if (tgt_ff > gap_start_ff) begin
               dir_up_in  = 1'b1;
               left_in    = tgt_ff - gap_start_ff;
               rd_addr_in = gap_start_ff + gap_len_ff;
               wr_addr_in = gap_start_ff;
               state_in   = ST_MOVE;
            end else begin
               state_in = ST_COMMIT;
            end
         end

         // One entry read and the previous one written each cycle
         ST_MOVE: begin
            if (left_ff != '0) begin
               rd.en      = 1'b1;
               rd.addr    = rd_addr_ff[ADDR_W-1:0];
               rd_addr_in = dir_up_ff ? rd_addr_ff + POS_W'(1) : rd_addr_ff - POS_W'(1);
               left_in    = left_ff - POS_W'(1);
            end
            if (wr_pend_ff) begin
               wr.en      = 1'b1;
               wr.addr    = wr_addr_ff[ADDR_W-1:0];
               wr.data    = rd_data;
               wr_addr_in = dir_up_ff ? wr_addr_ff + POS_W'(1) : wr_addr_ff - POS_W'(1);
            end
            wr_pend_in = (left_ff != '0);
            if (left_ff == '0) begin
               state_in = ST_COMMIT;
            end
         end

         ST_COMMIT: begin
            gap_start_in = tgt_ff;
            gap_len_in   = gap_len_ff + grow_ff;
            cursor_in    = new_cur_ff;
            state_in     = ST_RESP;
         end

         ST_RDWAIT: begin
            rcode_in  = rd_data;
            rvalid_in = 1'b1;
            state_in  = ST_RESP;
         end

         ST_RESP: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gap_start_ff <= '0;
         gap_len_ff   <= POS_W'(CAPACITY);
         cursor_ff    <= -$signed(POS_W'(1));
      end else begin
         state_ff     <= state_in;
         gap_start_ff <= gap_start_in;
         gap_len_ff   <= gap_len_in;
         cursor_ff    <= cursor_in;
      end
   end

   // Request, plan and result payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      cpos_ff     <= cpos_in;
      has_mark_ff <= has_mark_in;
      mark_ff     <= mark_in;
      code_ff     <= code_in;
      ridx_ff     <= ridx_in;
      tgt_ff      <= tgt_in;
      grow_ff     <= grow_in;
      new_cur_ff  <= new_cur_in;
      dir_up_ff   <= dir_up_in;
      left_ff     <= left_in;
      rd_addr_ff  <= rd_addr_in;
      wr_addr_ff  <= wr_addr_in;
      wr_pend_ff  <= wr_pend_in;
      rcode_ff    <= rcode_in;
      rvalid_ff   <= rvalid_in;
      drop_ff     <= drop_in;
   end

   // Outputs
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_RESP);
   assign rsp_read_code    = rcode_ff;
   assign rsp_read_valid   = rvalid_ff;
   assign rsp_cursor_now   = cursor_ff;
   assign rsp_gap_position = gap_start_ff;
   assign rsp_gap_size     = gap_len_ff;
   assign rsp_full_drop    = drop_ff;

   // Gap never runs past the end of the store
   a_gap_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, gap_start_ff} + {1'b0, gap_len_ff}) <= (POS_W+1)'(CAPACITY))
      else $error("gap extends past end of store");

   // Between requests the cursor sits just before the gap
   a_cursor_gap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($unsigned(cursor_ff) == gap_start_ff - POS_W'(1)))
      else $error("cursor and gap start disagree");

   // A slide never reads and writes the same slot in one cycle
   a_port_clash: assert property (@(posedge clock) disable iff (reset)
      (wr.en && rd.en) |-> (wr.addr != rd.addr))
      else $error("read and write hit the same slot");

   // The result beat ends the request
   a_resp_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("still busy after result beat");

   // A refused insert only happens on a full store
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_full_drop) |-> (gap_len_ff == '0))
      else $error("insert refused with free slots");

endmodule

@@ design/gbte_ram.sv @@
// Text memory of the gap buffer: one write port, one read port with
// registered read data. Depends on gbte_pkg.
module gbte_ram
   import gbte_pkg::*;
(
   input  logic                 clock,
   input  ram_wr_type           wr,
   input  ram_rd_type           rd,
   output logic [CODE_BITS-1:0] rd_data
);

   logic [CODE_BITS-1:0] text_store_ff [CAPACITY];
   logic [CODE_BITS-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         text_store_ff[wr.addr] <= wr.data;
      end
   end

   // Read port, read data registered from the addressed slot
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= text_store_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
